FILE: design/message_buffer_page_allocator_defines.svh
// Assertion macros shared by the page allocator RTL.
`ifndef MESSAGE_BUFFER_PAGE_ALLOCATOR_DEFINES_SVH
`define MESSAGE_BUFFER_PAGE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MBPA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define MBPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mbpa_pkg.sv
// Package with constants, types and codes of the message buffer page allocator.
`timescale 1ns / 1ps
package mbpa_pkg;
	localparam int POOL_PAGES  = 256;
	localparam int PAGE_SHIFT  = 16;
	localparam int MAX_BUFFERS = 16;
	localparam int CORE_COUNT  = 8;
	localparam int MIN_SPARE   = 4;

	localparam int PAGE_W  = $clog2(POOL_PAGES);
	localparam int PCNT_W  = 9;
	localparam int CORE_W  = 3;
	localparam int LEN_W   = 20;
	localparam int OFF_W   = 24;
	localparam int FULL_W  = LEN_W - PAGE_SHIFT;
	localparam int USED_W  = PAGE_SHIFT + 1;
	localparam int BIDX_W  = $clog2(MAX_BUFFERS);
	localparam int BCNT_W  = BIDX_W + 1;
	localparam int REFS_W  = 16;
	localparam int TIME_W  = 64;
	localparam int LEASE_W = 32;
	localparam int CFG_W   = 32;

	typedef struct packed {
		logic [REFS_W-1:0] refs;
		logic              owned;
		logic [CORE_W-1:0] owner;
		logic [TIME_W-1:0] expiry;
	} page_ent_t;

	localparam int ENT_W = $bits(page_ent_t);

	typedef enum logic [1:0] {
		ST_ALLOC    = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_RELEASED = 2'd2,
		ST_IGNORED  = 2'd3
	} status_t;

	localparam logic KIND_ALLOC   = 1'b0;
	localparam logic KIND_RELEASE = 1'b1;

	localparam logic REG_PAGE_COUNT = 1'b0;
	localparam logic REG_LEASE_TIME = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REL_EV,
		S_PART,
		S_PART_EV,
		S_TAKE,
		S_SCAN,
		S_SCAN_EV,
		S_FAIL_DROP,
		S_EMIT
	} state_t;
endpackage

FILE: design/mbpa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module mbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: design/message_buffer_page_allocator.sv
// Top level of the message buffer page allocator.
// The page descriptors (reference count, owner, lease expiry) live in one RAM with a
// registered read; a valid bit per page makes a page that was never written since reset
// or the last page_count write read as free. Items are handled one at a time. A release
// reads the page descriptor, updates it and then emits its results; when its offset lies
// outside the pool in use it goes straight to the results. An allocate reads and checks
// each page descriptor visited by the per-core scan, restarts the scan at page 0 on a
// wrap, checks the partial page, gives back its pages one by one on failure and then
// emits its results. Writing page_count re-initializes the pool at once.
`timescale 1ns / 1ps
`include "message_buffer_page_allocator_defines.svh"
module message_buffer_page_allocator import mbpa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              kind,
	input  logic [LEN_W-1:0]  message_length,
	input  logic [CORE_W-1:0] core_id,
	input  logic [TIME_W-1:0] time_now,
	input  logic [OFF_W-1:0]  release_offset,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        status,
	output logic              buffer_valid,
	output logic [OFF_W-1:0]  buffer_offset,
	output logic              last,
	output logic [PCNT_W-1:0] free_pages
);
	state_t state_q, state_d;

	// Pool registers.
	logic [PCNT_W-1:0]  pc_q;
	logic [LEASE_W-1:0] lease_q;
	logic [PCNT_W-1:0]  free_q;
	logic [PCNT_W-1:0]  scan_next_q [CORE_COUNT];
	logic [PAGE_W-1:0]  hint_page_q [CORE_COUNT];
	logic [USED_W-1:0]  hint_used_q [CORE_COUNT];
	logic [POOL_PAGES-1:0] vld_q;

	// Item registers.
	logic [FULL_W-1:0]     full_q;
	logic [PAGE_SHIFT-1:0] part_q;
	logic [CORE_W-1:0]     core_q;
	logic [TIME_W-1:0]     now_q;
	logic [PCNT_W-1:0]     lim_q;
	logic                  own_q;
	logic [BCNT_W-1:0]     n_q;
	logic [BIDX_W-1:0]     oidx_q;
	logic [BIDX_W-1:0]     drop_q;
	status_t               status_q;
	logic                  bv_q;
	logic [OFF_W-1:0]      list_q [MAX_BUFFERS];
	logic [PAGE_W-1:0]     scan_cur_q;

	// RAM port.
	logic              ram_we;
	logic [PAGE_W-1:0] ram_waddr, ram_raddr;
	page_ent_t         ram_wdata;
	logic [ENT_W-1:0]  ram_rdata;
	logic              rvld_s1;
	page_ent_t         ent;

	mbpa_ram #(.WIDTH(ENT_W), .DEPTH(POOL_PAGES)) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign ent = rvld_s1 ? page_ent_t'(ram_rdata) : '0;

	// Decode of the incoming allocate or release.
	logic [FULL_W-1:0]     in_full;
	logic [PAGE_SHIFT-1:0] in_part;
	logic [BCNT_W-1:0]     in_total;
	logic [PAGE_W-1:0]     in_rel_page;
	logic                  in_acc;
	assign in_full     = message_length[LEN_W-1 -: FULL_W];
	assign in_part     = message_length[PAGE_SHIFT-1:0];
	assign in_total    = BCNT_W'(in_full) + BCNT_W'(in_part != '0);
	assign in_rel_page = release_offset[PAGE_SHIFT +: PAGE_W];
	assign in_acc      = in_valid && in_ready;

	// Scan limit from the pages in use.
	logic [PCNT_W-1:0] used, extra, spare, lim_eff, cur;
	logic [PCNT_W:0]   lim_sum;
	assign used    = (free_q > pc_q) ? '0 : pc_q - free_q;
	assign extra   = used >> 2;
	assign spare   = (extra < PCNT_W'(MIN_SPARE)) ? PCNT_W'(MIN_SPARE) : extra;
	assign lim_sum = {1'b0, used} + {1'b0, spare};
	always_comb begin
		if (lim_q != '0) begin
			lim_eff = lim_q;
		end else if (lim_sum > {1'b0, pc_q}) begin
			lim_eff = pc_q;
		end else begin
			lim_eff = lim_sum[PCNT_W-1:0];
		end
	end
	assign cur = scan_next_q[core_q];

	// Page checks.
	logic [TIME_W-1:0]     exp_new;
	logic                  steal, take_ok;
	logic [PAGE_W-1:0]     hp;
	logic                  hp_match, ovf, reuse;
	logic [USED_W:0]       used_sum;
	logic [PAGE_SHIFT-1:0] used_eff;
	assign exp_new  = now_q + TIME_W'(lease_q);
	assign steal    = (ent.refs == REFS_W'(1)) && ent.owned && (ent.expiry <= now_q);
	assign take_ok  = (ent.refs == '0) || steal;
	assign hp       = hint_page_q[core_q];
	assign hp_match = ent.owned && (ent.owner == core_q);
	assign used_sum = {1'b0, hint_used_q[core_q]} + (USED_W + 1)'(part_q);
	assign ovf      = used_sum > (USED_W + 1)'(1 << PAGE_SHIFT);
	assign reuse    = hp_match && (!ovf || ent.refs == REFS_W'(1));
	assign used_eff = ovf ? '0 : hint_used_q[core_q][PAGE_SHIFT-1:0];

	// Next state and RAM control.
	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_raddr = '0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				ram_raddr = in_rel_page;
				if (in_acc) begin
					if (kind == KIND_RELEASE) begin
						state_d = ({1'b0, in_rel_page} < pc_q) ? S_REL_EV : S_EMIT;
					end else if (in_total > BCNT_W'(MAX_BUFFERS)) begin
						state_d = S_EMIT;
					end else if (in_full != '0) begin
						state_d = (free_q < PCNT_W'(in_full)) ? S_EMIT : S_SCAN;
					end else if (in_part != '0) begin
						state_d = S_PART;
					end else begin
						state_d = S_EMIT;
					end
				end
			end
			S_REL_EV: begin
				if (ent.refs != '0) begin
					ram_we        = 1'b1;
					ram_waddr     = now_q[PAGE_W-1:0];
					ram_wdata     = ent;
					ram_wdata.refs = ent.refs - REFS_W'(1);
				end
				state_d = S_EMIT;
			end
			S_PART: begin
				ram_raddr = hp;
				state_d   = ({1'b0, hp} < pc_q) ? S_PART_EV : S_TAKE;
			end
			S_PART_EV: begin
				ram_waddr = hp;
				ram_wdata = ent;
				if (reuse) begin
					ram_we           = 1'b1;
					ram_wdata.expiry = exp_new;
					if (ent.refs != '1) begin
						ram_wdata.refs = ent.refs + REFS_W'(1);
					end
					state_d = S_EMIT;
				end else begin
					if (hp_match) begin
						ram_we          = 1'b1;
						ram_wdata.owned = 1'b0;
						if (ent.refs != '0) begin
							ram_wdata.refs = ent.refs - REFS_W'(1);
						end
					end
					state_d = S_TAKE;
				end
			end
			S_TAKE: begin
				if (free_q == '0) begin
					state_d = (full_q != '0) ? S_FAIL_DROP : S_EMIT;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				ram_raddr = cur[PAGE_W-1:0];
				if (cur < lim_eff) begin
					state_d = S_SCAN_EV;
				end
			end
			S_SCAN_EV: begin
				ram_waddr = scan_cur_q;
				if (take_ok) begin
					ram_we = 1'b1;
					if (own_q) begin
						ram_wdata.refs   = REFS_W'(2);
						ram_wdata.owned  = 1'b1;
						ram_wdata.owner  = core_q;
						ram_wdata.expiry = exp_new;
						state_d = S_EMIT;
					end else begin
						ram_wdata.refs = REFS_W'(1);
						if (n_q + BCNT_W'(1) == BCNT_W'(full_q)) begin
							state_d = (part_q != '0) ? S_PART : S_EMIT;
						end else begin
							state_d = S_SCAN;
						end
					end
				end else begin
					state_d = S_SCAN;
				end
			end
			S_FAIL_DROP: begin
				ram_we    = 1'b1;
				ram_waddr = list_q[drop_q][PAGE_SHIFT +: PAGE_W];
				if (BCNT_W'(drop_q) + BCNT_W'(1) == n_q) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				out_valid = 1'b1;
				if (out_ready && last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Pool state: per-core entries, free count, valid bits and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= PCNT_W'(POOL_PAGES);
			lease_q <= '0;
			free_q  <= PCNT_W'(POOL_PAGES);
			vld_q   <= '0;
			rvld_s1 <= 1'b0;
			for (int i = 0; i < CORE_COUNT; i++) begin
				scan_next_q[i] <= '0;
				hint_page_q[i] <= '0;
				hint_used_q[i] <= '0;
			end
		end else begin
			rvld_s1 <= vld_q[ram_raddr];
			if (ram_we) begin
				vld_q[ram_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && kind == KIND_ALLOC && in_total <= BCNT_W'(MAX_BUFFERS)
					    && in_full != '0 && free_q >= PCNT_W'(in_full)) begin
						free_q <= free_q - PCNT_W'(in_full);
					end
				end
				S_REL_EV: begin
					if (ent.refs == REFS_W'(1)) begin
						free_q <= free_q + PCNT_W'(1);
					end
				end
				S_PART_EV: begin
					if (reuse) begin
						hint_used_q[core_q] <= USED_W'(used_eff) + USED_W'(part_q);
					end else if (hp_match && ent.refs == REFS_W'(1)) begin
						free_q <= free_q + PCNT_W'(1);
					end
				end
				S_TAKE: begin
					if (free_q != '0) begin
						free_q <= free_q - PCNT_W'(1);
					end
				end
				S_SCAN: begin
					if (cur < lim_eff) begin
						scan_next_q[core_q] <= cur + PCNT_W'(1);
					end else begin
						scan_next_q[core_q] <= '0;
					end
				end
				S_SCAN_EV: begin
					if (take_ok) begin
						if (steal) begin
							free_q <= free_q + PCNT_W'(1);
						end
						if (own_q) begin
							hint_page_q[core_q] <= scan_cur_q;
							hint_used_q[core_q] <= USED_W'(part_q);
						end
					end
				end
				S_FAIL_DROP: begin
					free_q <= free_q + PCNT_W'(1);
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				case (cfg_index)
					REG_PAGE_COUNT: begin
						if (cfg_data[PCNT_W-1:0] < PCNT_W'(2)) begin
							pc_q   <= PCNT_W'(2);
							free_q <= PCNT_W'(2);
						end else if (cfg_data[PCNT_W-1:0] > PCNT_W'(POOL_PAGES)) begin
							pc_q   <= PCNT_W'(POOL_PAGES);
							free_q <= PCNT_W'(POOL_PAGES);
						end else begin
							pc_q   <= cfg_data[PCNT_W-1:0];
							free_q <= cfg_data[PCNT_W-1:0];
						end
						vld_q <= '0;
						for (int i = 0; i < CORE_COUNT; i++) begin
							scan_next_q[i] <= '0;
							hint_page_q[i] <= '0;
							hint_used_q[i] <= '0;
						end
					end
					REG_LEASE_TIME: begin
						lease_q <= cfg_data[LEASE_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Item registers and the result list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oidx_q <= '0;
			n_q    <= '0;
			lim_q  <= '0;
			own_q  <= 1'b0;
			drop_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						full_q   <= in_full;
						part_q   <= in_part;
						core_q   <= core_id;
						now_q    <= time_now;
						oidx_q   <= '0;
						n_q      <= '0;
						lim_q    <= '0;
						own_q    <= 1'b0;
						drop_q   <= '0;
						bv_q     <= 1'b0;
						status_q <= ST_ALLOC;
						if (kind == KIND_RELEASE) begin
							now_q    <= TIME_W'(in_rel_page);
							status_q <= ST_IGNORED;
						end else if (in_total > BCNT_W'(MAX_BUFFERS)
						             || (in_full != '0 && free_q < PCNT_W'(in_full))) begin
							status_q <= ST_NOSPACE;
						end
					end
				end
				S_REL_EV: begin
					if (ent.refs != '0) begin
						status_q <= ST_RELEASED;
					end
				end
				S_PART_EV: begin
					if (reuse) begin
						list_q[n_q[BIDX_W-1:0]] <= OFF_W'({hp, used_eff});
						n_q  <= n_q + BCNT_W'(1);
						bv_q <= 1'b1;
					end
				end
				S_TAKE: begin
					own_q <= 1'b1;
					lim_q <= '0;
					if (free_q == '0) begin
						status_q <= ST_NOSPACE;
					end
				end
				S_SCAN: begin
					scan_cur_q <= cur[PAGE_W-1:0];
					lim_q      <= (cur < lim_eff) ? lim_eff : '0;
				end
				S_SCAN_EV: begin
					if (take_ok) begin
						list_q[n_q[BIDX_W-1:0]] <= OFF_W'({scan_cur_q, {PAGE_SHIFT{1'b0}}});
						n_q  <= n_q + BCNT_W'(1);
						bv_q <= 1'b1;
					end
				end
				S_FAIL_DROP: begin
					drop_q <= drop_q + BIDX_W'(1);
					bv_q   <= 1'b0;
				end
				S_EMIT: begin
					if (out_ready && !last) begin
						oidx_q <= oidx_q + BIDX_W'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign status        = status_q;
	assign buffer_valid  = bv_q;
	assign buffer_offset = bv_q ? list_q[oidx_q] : '0;
	assign last          = !bv_q || (BCNT_W'(oidx_q) + BCNT_W'(1) == n_q);
	assign free_pages    = free_q;

	`MBPA_ASSERT_NOW(a_free_bound, 1'b1, free_q <= pc_q, "free count exceeds page count")
	`MBPA_ASSERT_NOW(a_write_in_pool, ram_we, {1'b0, ram_waddr} < pc_q,
		"page write outside the pool in use")
	`MBPA_ASSERT_NEXT(a_burst_holds, out_valid && out_ready && !last, out_valid,
		"result burst ended before its last transfer")
	`MBPA_ASSERT_NOW(a_buf_index, out_valid && bv_q, BCNT_W'(oidx_q) < n_q,
		"result index beyond the buffer list")
endmodule
